@@ src/bb3_pkg.sv @@
// shared types, constants and the reciprocal table for the 3x3 box blur
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int FRAME_W_W   = 11;
  localparam int FRAME_H_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 12'd768;

  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int DIV_X_W     = 13;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = DIV_X_W + RECIP_W;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum_t;

  // ceil(2^17 / (2n)), exact for every numerator up to 2*9*255+9
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

@@ src/bb3_mean.sv @@
// rounded mean of three channel sums, by reciprocal multiplication
module bb3_mean (
  input  logic                      clk,
  input  bb3_pkg::sum_t             sums,
  input  logic [bb3_pkg::CNT_W-1:0] cnt,
  output bb3_pkg::rgb_t             mean
);

  logic [bb3_pkg::RECIP_W-1:0] m;
  logic [bb3_pkg::DIV_X_W-1:0] x_r, x_g, x_b;
  logic [bb3_pkg::PROD_W-1:0]  p_r, p_g, p_b;

  always_comb begin
    m   = bb3_pkg::recip(cnt);
    x_r = bb3_pkg::DIV_X_W'({sums.r, 1'b0}) + bb3_pkg::DIV_X_W'(cnt);
    x_g = bb3_pkg::DIV_X_W'({sums.g, 1'b0}) + bb3_pkg::DIV_X_W'(cnt);
    x_b = bb3_pkg::DIV_X_W'({sums.b, 1'b0}) + bb3_pkg::DIV_X_W'(cnt);
  end

  always_ff @(posedge clk) begin
    p_r <= bb3_pkg::PROD_W'(x_r) * bb3_pkg::PROD_W'(m);
    p_g <= bb3_pkg::PROD_W'(x_g) * bb3_pkg::PROD_W'(m);
    p_b <= bb3_pkg::PROD_W'(x_b) * bb3_pkg::PROD_W'(m);
  end

  assign mean.r = p_r[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
  assign mean.g = p_g[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
  assign mean.b = p_b[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];

endmodule

@@ src/box_blur_3x3_rgb.sv @@
// top level of the 3x3 box blur over a raster stream of rgb pixels
//
// Input channel (in_valid / in_stall): operation 0 carries a pixel, 1 is a
// drain tick. Pixels of one frame arrive in raster order; once the frame is
// complete, frame_width drain ticks flush the final row, the last result
// carrying frame_last. Output channel (out_valid / out_stall): one blurred
// pixel per transfer. Configuration (cfg_valid / cfg_ready, cfg_index,
// cfg_data) sets frame_width (index 0) and frame_height (index 1); a write
// restarts the frame and is only taken while the block is idle.
// A pixel that closes no output passes only the read state; each result it
// closes adds sum, multiply and put, and a drain tick runs drain read, one
// column per step, then multiply and put. The steps follow from the one-port
// line stores (one column read per cycle, written back in the following
// cycle) and from the single sum / multiply path shared by results.
// While the output register is full and stalled, the block keeps working
// on the next item and holds only when it must place a new result.
// Synchronous reset clears positions, window and out_valid; the line
// stores need no clearing.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [bb3_pkg::CHAN_W-1:0]     in_red,
  input  logic [bb3_pkg::CHAN_W-1:0]     in_green,
  input  logic [bb3_pkg::CHAN_W-1:0]     in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bb3_pkg::CHAN_W-1:0]     out_red,
  output logic [bb3_pkg::CHAN_W-1:0]     out_green,
  output logic [bb3_pkg::CHAN_W-1:0]     out_blue,
  output logic                           frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]                     state;
  logic [bb3_pkg::FRAME_W_W-1:0]  frame_width;
  logic [bb3_pkg::FRAME_H_W-1:0]  frame_height;
  logic [AW-1:0]                  col;
  logic [bb3_pkg::FRAME_H_W-1:0]  row;
  logic [AW-1:0]                  drain;
  bb3_pkg::rgb_t                  win [9];
  bb3_pkg::rgb_t                  win_next [9];
  bb3_pkg::rgb_t                  pix_reg;

  bb3_pkg::rgb_t                  older_mem [MAX_WIDTH];
  bb3_pkg::rgb_t                  newer_mem [MAX_WIDTH];
  bb3_pkg::rgb_t                  old_q, new_q;
  logic [AW-1:0]                  mem_addr;
  logic                           mem_we;

  logic                           r_lo;
  logic [1:0]                     c_lo;
  logic                           second;
  logic [1:0]                     second_c_lo;
  logic                           last_flag;
  logic [AW-1:0]                  dr_col, dr_hi;

  bb3_pkg::sum_t                  acc, win_sum, d_sum;
  logic [bb3_pkg::CNT_W-1:0]      cnt, win_cnt, d_cnt;
  bb3_pkg::rgb_t                  mean;

  logic [WW-1:0]                  eff_w, last_col, k_w, lo_w, hi_w;
  logic [bb3_pkg::FRAME_H_W-1:0]  eff_h;
  logic                           at_last, have_a, have_b, two_rows, dr_last;
  logic [1:0]                     col_lo_a, col_lo_b;
  logic                           cfg_hit, pix_take, drn_take, restart;

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h    = (frame_height == '0) ? bb3_pkg::FRAME_H_W'(1) : frame_height;
    last_col = eff_w - WW'(1);
    two_rows = (eff_h >= bb3_pkg::FRAME_H_W'(2));
  end

  // pixel result selection
  always_comb begin
    at_last  = (WW'(col) == last_col);
    have_a   = (row != '0) && (col != '0);
    have_b   = (row != '0) && at_last;
    col_lo_a = (col >= AW'(2)) ? 2'd0 : 2'd1;
    col_lo_b = (col != '0) ? 2'd1 : 2'd2;
  end

  // drain column range
  always_comb begin
    k_w = WW'(drain);
    if (k_w >= eff_w) begin
      k_w = last_col;
    end
    lo_w    = (k_w != '0) ? k_w - WW'(1) : k_w;
    hi_w    = ((k_w + WW'(1)) < eff_w) ? k_w + WW'(1) : k_w;
    dr_last = (k_w == last_col);
  end

  always_comb begin
    cfg_ready = (state == S_IDLE);
    in_stall  = (state != S_IDLE);
    cfg_hit   = cfg_valid && cfg_ready &&
                (cfg_index == bb3_pkg::REG_FRAME_WIDTH ||
                 cfg_index == bb3_pkg::REG_FRAME_HEIGHT);
    pix_take  = (state == S_IDLE) && in_valid && !operation && (row < eff_h);
    drn_take  = (state == S_IDLE) && in_valid && operation && (row >= eff_h);
    restart   = cfg_hit || (drn_take && dr_last);
    mem_we    = (state == S_READ);
  end

  always_comb begin
    case (state)
      S_IDLE:  mem_addr = operation ? AW'(lo_w) : col;
      S_DRD:   mem_addr = dr_col + AW'(1);
      default: mem_addr = col;
    endcase
  end

  // line stores: read every cycle, written back in the cycle after the read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      older_mem[col] <= new_q;
      newer_mem[col] <= pix_reg;
    end
    old_q <= older_mem[mem_addr];
    new_q <= newer_mem[mem_addr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3]     = win[i*3+1];
      win_next[i*3 + 1] = win[i*3+2];
    end
    win_next[2] = old_q;
    win_next[5] = new_q;
    win_next[8] = pix_reg;
  end

  always_comb begin
    win_sum = '0;
    win_cnt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i >= int'(r_lo) && j >= int'(c_lo)) begin
          win_sum.r = win_sum.r + bb3_pkg::SUM_W'(win[i*3+j].r);
          win_sum.g = win_sum.g + bb3_pkg::SUM_W'(win[i*3+j].g);
          win_sum.b = win_sum.b + bb3_pkg::SUM_W'(win[i*3+j].b);
          win_cnt   = win_cnt + bb3_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    d_sum.r = acc.r + bb3_pkg::SUM_W'(new_q.r) +
              (two_rows ? bb3_pkg::SUM_W'(old_q.r) : '0);
    d_sum.g = acc.g + bb3_pkg::SUM_W'(new_q.g) +
              (two_rows ? bb3_pkg::SUM_W'(old_q.g) : '0);
    d_sum.b = acc.b + bb3_pkg::SUM_W'(new_q.b) +
              (two_rows ? bb3_pkg::SUM_W'(old_q.b) : '0);
    d_cnt   = cnt + (two_rows ? bb3_pkg::CNT_W'(2) : bb3_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FRAME_WIDTH_RST;
      frame_height <= bb3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[bb3_pkg::FRAME_W_W-1:0];
      end else if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      drain     <= '0;
      second    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pix_take) begin
            pix_reg <= '{r: in_red, g: in_green, b: in_blue};
            state   <= S_READ;
          end else if (drn_take) begin
            acc       <= '0;
            cnt       <= '0;
            dr_col    <= AW'(lo_w);
            dr_hi     <= AW'(hi_w);
            last_flag <= dr_last;
            drain     <= AW'(k_w + WW'(1));
            state     <= S_DRD;
          end
        end
        S_READ: begin
          win       <= win_next;
          last_flag <= 1'b0;
          r_lo      <= (row >= bb3_pkg::FRAME_H_W'(2)) ? 1'b0 : 1'b1;
          if (at_last) begin
            col   <= '0;
            row   <= row + bb3_pkg::FRAME_H_W'(1);
            drain <= '0;
          end else begin
            col <= col + AW'(1);
          end
          if (have_a) begin
            c_lo        <= col_lo_a;
            second      <= have_b;
            second_c_lo <= col_lo_b;
            state       <= S_SUM;
          end else if (have_b) begin
            c_lo   <= col_lo_b;
            second <= 1'b0;
            state  <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          acc   <= win_sum;
          cnt   <= win_cnt;
          state <= S_MUL;
        end
        S_DRD: begin
          acc <= d_sum;
          cnt <= d_cnt;
          if (dr_col == dr_hi) begin
            state <= S_MUL;
          end else begin
            dr_col <= dr_col + AW'(1);
          end
        end
        S_MUL: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid || !out_stall) begin
            out_red    <= mean.r;
            out_green  <= mean.g;
            out_blue   <= mean.b;
            frame_last <= last_flag;
            out_valid  <= 1'b1;
            if (second) begin
              second <= 1'b0;
              c_lo   <= second_c_lo;
              state  <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (restart) begin
        col   <= '0;
        row   <= '0;
        drain <= '0;
        for (int i = 0; i < 9; i++) begin
          win[i] <= '0;
        end
      end
    end
  end

  bb3_mean u_mean (
    .clk  (clk),
    .sums (acc),
    .cnt  (cnt),
    .mean (mean)
  );

`ifndef ASSERT_OFF
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < eff_w)
    else $error("column position beyond frame width");

  a_mul_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> cnt != '0)
    else $error("mean taken over an empty neighbourhood");

  a_drain_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DRD |-> dr_col <= dr_hi)
    else $error("drain read past its last column");

  a_put_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && out_valid && out_stall) |=> state == S_PUT)
    else $error("result placed over a stalled output");
`endif

endmodule
